// ===== sv/csr_sparse_matrix_vector_multiply_unit_defines.svh =====
// Assertion helpers for the sparse matrix-vector unit.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSRMV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSRMV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csrmv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csrmv_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 48;
  localparam int DIM_W  = 11;

  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  // Depth of the result queue; must cover the back-end pipeline plus slack.
  localparam int OUT_DEPTH   = 8;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_MAC   = 2'd1;
  localparam cmd_t CMD_EMPTY = 2'd2;
  localparam cmd_t CMD_NONE  = 2'd3;

  typedef struct packed {
    cmd_t                     command;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] base;
    logic                     row_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row_index;
    logic signed [DATA_W-1:0] row_value;
    logic                     last_row;
    logic                     overflow;
  } result_t;

  // Classified operation handed from the front to the back end.
  typedef struct packed {
    cmd_t                     kind;
    logic [IDX_W-1:0]         index;
    logic                     in_range;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] base;
    logic                     row_last;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/csrmv_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrmv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/csrmv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrmv_front #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire csrmv_pkg::in_item_t item,
  output logic                    full,
  output logic                    q_valid,
  output csrmv_pkg::op_t          q_op,
  input  wire logic               q_pop
);

  localparam int OPW = $bits(csrmv_pkg::op_t);

  csrmv_pkg::op_t   op;
  logic [OPW-1:0]   q_data;
  logic             q_empty;
  logic             q_push;

  // Classify: drop unknown commands, flag indexes beyond the store.
  always_comb begin
    op.kind     = item.command;
    op.index    = item.index;
    op.in_range = (32'(item.index) < 32'(VECTOR_DEPTH));
    op.value    = item.value;
    op.base     = item.base;
    op.row_last = item.row_last;
  end

  assign q_push  = push && !full && (item.command != csrmv_pkg::CMD_NONE);
  assign q_valid = !q_empty;
  assign q_op    = csrmv_pkg::op_t'(q_data);

  csrmv_fifo #(
    .WIDTH (OPW),
    .DEPTH (csrmv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (OPW'(op)),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

endmodule

`default_nettype wire

// ===== sv/csrmv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csrmv_back #(
  parameter int VECTOR_DEPTH  = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [csrmv_pkg::DIM_W-1:0]        dim,
  input  wire logic                               q_valid,
  input  wire csrmv_pkg::op_t                     q_op,
  output logic                                    q_pop,
  input  wire logic                               pop,
  output logic                                    empty,
  output csrmv_pkg::result_t                      result
);

  localparam int AW   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int XW   = csrmv_pkg::IDX_W + AW;
  localparam int RW   = $clog2(csrmv_pkg::OUT_DEPTH + 1);
  localparam int DW   = csrmv_pkg::DATA_W;
  localparam int AccW = csrmv_pkg::ACC_W;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int ResW = $bits(csrmv_pkg::result_t);

  localparam logic signed [SW-1:0] ACC_MAX = SW'({1'b0, {(AccW-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

  // Vector store
  logic [DW-1:0]        vmem [VECTOR_DEPTH];
  logic [DW-1:0]        rd_data;
  logic [XW-1:0]        idx_x;
  logic [AW-1:0]        addr;

  // Issue control
  logic                 head_emits;
  logic                 credit_ok;
  logic [RW-1:0]        reserved;
  logic                 res_pop;

  // Stage 1: read data arrives
  logic                 s1_valid;
  csrmv_pkg::cmd_t      s1_kind;
  logic                 s1_last;
  logic                 s1_in_range;
  logic signed [DW-1:0] s1_value;
  logic signed [DW-1:0] s1_base;
  logic signed [DW-1:0] x_sel;
  logic signed [PW-1:0] prod;

  // Stage 2: accumulate
  logic                 s2_valid;
  csrmv_pkg::cmd_t      s2_kind;
  logic                 s2_last;
  logic signed [DW-1:0] s2_base;
  logic signed [PW-1:0] s2_prod;
  logic signed [PW-1:0] term;
  logic signed [AccW-1:0] start;
  logic signed [SW-1:0] sum;
  logic signed [AccW-1:0] sat;
  logic signed [AccW-1:0] acc;
  logic                 row_open;
  logic [csrmv_pkg::IDX_W-1:0] row_counter;
  logic [csrmv_pkg::DIM_W-1:0] rc_plus;
  logic                 at_last_row;
  logic                 s2_emit;
  logic signed [AccW-1:0] emit_value;

  // Stage 3: clamp and push
  logic                 s3_valid;
  logic signed [AccW-1:0] s3_value;
  logic [csrmv_pkg::IDX_W-1:0] s3_row;
  logic                 s3_last_row;
  csrmv_pkg::result_t   res_in;
  logic [ResW-1:0]      res_data;
  logic                 res_full;

  assign idx_x = XW'(q_op.index);
  assign addr  = idx_x[AW-1:0];

  assign head_emits = (q_op.kind == csrmv_pkg::CMD_EMPTY) ||
                      ((q_op.kind == csrmv_pkg::CMD_MAC) && q_op.row_last);
  assign credit_ok  = (reserved < RW'(csrmv_pkg::OUT_DEPTH));
  assign q_pop      = q_valid && (!head_emits || credit_ok);
  assign res_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (q_pop && (q_op.kind == csrmv_pkg::CMD_LOAD) && q_op.in_range) begin
      vmem[addr] <= q_op.value;
    end
    if (q_pop && (q_op.kind == csrmv_pkg::CMD_MAC)) begin
      rd_data <= vmem[addr];
    end
  end

  // Hold a result-queue slot for every issued row result.
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      unique case ({q_pop && head_emits, res_pop})
        2'b10:   reserved <= reserved + 1'b1;
        2'b01:   reserved <= reserved - 1'b1;
        default: reserved <= reserved;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop && (q_op.kind != csrmv_pkg::CMD_LOAD);
    end
    s1_kind     <= q_op.kind;
    s1_last     <= q_op.row_last;
    s1_in_range <= q_op.in_range;
    s1_value    <= q_op.value;
    s1_base     <= q_op.base;
  end

  assign x_sel = s1_in_range ? $signed(rd_data) : '0;
  assign prod  = s1_value * x_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_kind <= s1_kind;
    s2_last <= s1_last;
    s2_base <= s1_base;
    s2_prod <= prod;
  end

  // Floor shift, then a saturating add into the 48-bit accumulator.
  assign term  = s2_prod >>> FRACTION_BITS;
  assign start = row_open ? acc : AccW'(s2_base);
  assign sum   = SW'(term) + SW'(start);

  always_comb begin
    if (sum > ACC_MAX) begin
      sat = ACC_MAX[AccW-1:0];
    end else if (sum < ACC_MIN) begin
      sat = ACC_MIN[AccW-1:0];
    end else begin
      sat = sum[AccW-1:0];
    end
  end

  assign s2_emit     = s2_valid && ((s2_kind == csrmv_pkg::CMD_EMPTY) || s2_last);
  assign emit_value  = (s2_kind == csrmv_pkg::CMD_EMPTY) ? AccW'(s2_base) : sat;
  assign rc_plus     = csrmv_pkg::DIM_W'(row_counter) + 1'b1;
  assign at_last_row = (rc_plus >= dim);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      row_open    <= 1'b0;
      row_counter <= '0;
      s3_valid    <= 1'b0;
    end else begin
      s3_valid <= s2_emit;
      if (s2_valid) begin
        if (s2_emit) begin
          acc      <= '0;
          row_open <= 1'b0;
        end else begin
          acc      <= sat;
          row_open <= 1'b1;
        end
      end
      if (s2_emit) begin
        row_counter <= at_last_row ? '0 : rc_plus[csrmv_pkg::IDX_W-1:0];
      end
    end
    s3_value    <= emit_value;
    s3_row      <= row_counter;
    s3_last_row <= at_last_row;
  end

  always_comb begin
    res_in.row_index = s3_row;
    res_in.last_row  = s3_last_row;
    if (s3_value[AccW-1:DW-1] == '0 || s3_value[AccW-1:DW-1] == '1) begin
      res_in.row_value = s3_value[DW-1:0];
      res_in.overflow  = 1'b0;
    end else begin
      res_in.row_value = s3_value[AccW-1] ? {1'b1, {(DW-1){1'b0}}}
                                          : {1'b0, {(DW-1){1'b1}}};
      res_in.overflow  = 1'b1;
    end
  end

  assign result = csrmv_pkg::result_t'(res_data);

  csrmv_fifo #(
    .WIDTH (ResW),
    .DEPTH (csrmv_pkg::OUT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (s3_valid),
    .wdata (ResW'(res_in)),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_data),
    .empty (empty)
  );

  // The slot reservation keeps the result queue from overflowing.
  logic unused_full;
  assign unused_full = res_full;

endmodule

`default_nettype wire

// ===== sv/csr_sparse_matrix_vector_multiply_unit.sv =====
// Sparse (CSR order) matrix times dense vector, Q16.16 fixed point.
//
// Input queue: drive item and push; a transaction completes at a rising
// edge with push high and full low. Command load writes one vector element,
// command nonzero multiplies value by the stored element at index and adds
// it into the row accumulator (seeded from base on the first entry of a
// row), and command empty row passes base straight through.
// Result queue: while empty is low the oldest row result sits on result;
// pop high at a rising edge takes it.
// Configuration: cfg_wen with cfg_wdata sets the row count (0 acts as 1,
// above 1024 acts as 1024). Write it only while the block is idle.
// Path: a row result passes the queue, store read, multiply, accumulate and
// clamp stages between the acceptance of its closing item and result.
// Throughput: one item per cycle, set by the accumulate loop, while row results
// find free result-queue slots. When pop stays low the 8-entry result queue
// fills, the back end stops issuing, the 4-entry command queue fills and full rises.
// Reset (rst, synchronous) empties both queues, clears the accumulator and
// row counter and restores the row count to 1024; the vector store is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_unit_defines.svh"

module csr_sparse_matrix_vector_multiply_unit #(
  parameter int VECTOR_DEPTH  = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input queue
  input  wire logic                        push,
  input  wire csrmv_pkg::in_item_t         item,
  output logic                             full,
  // result queue
  input  wire logic                        pop,
  output logic                             empty,
  output csrmv_pkg::result_t               result,
  // configuration
  input  wire logic                        cfg_wen,
  input  wire logic [csrmv_pkg::DIM_W-1:0] cfg_wdata
);

  logic [csrmv_pkg::DIM_W-1:0] dim;
  logic [csrmv_pkg::DIM_W-1:0] dim_next;
  logic                        q_valid;
  logic                        q_pop;
  csrmv_pkg::op_t              q_op;

  // Clamp the row count on write so the back end sees only legal values.
  always_comb begin
    priority if (cfg_wdata == '0) begin
      dim_next = csrmv_pkg::DIM_W'(1);
    end else if (cfg_wdata > csrmv_pkg::MAX_DIM) begin
      dim_next = csrmv_pkg::MAX_DIM;
    end else begin
      dim_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= csrmv_pkg::MAX_DIM;
    end else if (cfg_wen) begin
      dim <= dim_next;
    end
  end

  // Front end: accept, classify and queue transactions.
  csrmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  // Back end: vector store, multiply, accumulate and result queue.
  csrmv_back #(
    .VECTOR_DEPTH  (VECTOR_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .dim     (dim),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // Never take an operation from an empty command queue.
  `CSRMV_ASSERT_IMP(a_pop_needs_valid, clk, rst, q_pop, q_valid, "pop from empty command queue")

  // Coming out of reset there is no result waiting.
  `CSRMV_ASSERT_IMP(a_empty_after_reset, clk, rst, $past(rst), empty, "result after reset")

  // A queued transaction leaves the command queue non-empty next cycle.
  `CSRMV_ASSERT_NXT(a_push_lands, clk, rst,
    push && !full && (item.command != csrmv_pkg::CMD_NONE), q_valid,
    "accepted transaction lost")

endmodule

`default_nettype wire
